[hdl/lgs_pkg.sv]
// package for the life grid generation step unit
// holds grid sizes, widths, opcodes, register indexes and rule constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lgs_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
  localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
  localparam int STEP_W    = $clog2(MAX_ROWS + 3);

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(MAX_ROWS);
  localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(MAX_COLS);

  localparam int SUM_W = 4;
  localparam logic [SUM_W-1:0] BIRTH_SUM = SUM_W'(3);
  localparam logic [SUM_W-1:0] KEEP_SUM  = SUM_W'(2);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2
  } op_e;

endpackage

`default_nettype wire

[hdl/lgs_ram.sv]
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lgs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/lgs_row_update.sv]
// next-generation logic for one grid row from its old row and the rows around it
// depends on lgs_pkg
`timescale 1ns / 1ps
`default_nettype none

module lgs_row_update
  import lgs_pkg::*;
(
  input  wire logic [MAX_COLS-1:0]  up_i,
  input  wire logic [MAX_COLS-1:0]  mid_i,
  input  wire logic [MAX_COLS-1:0]  dn_i,
  input  wire logic [COL_CNT_W-1:0] ncols_i,
  output logic      [MAX_COLS-1:0]  next_o
);

  logic [COL_W-1:0] last_col;

  assign last_col = COL_W'(ncols_i - COL_CNT_W'(1));

  for (genvar j = 0; j < MAX_COLS; j++) begin : g_lane
    logic             up_l, mid_l, dn_l, up_r, mid_r, dn_r;
    logic             active;
    logic [SUM_W-1:0] sum;

    if (j == 0) begin : g_lf_wrap
      assign up_l  = up_i[last_col];
      assign mid_l = mid_i[last_col];
      assign dn_l  = dn_i[last_col];
    end else begin : g_lf
      assign up_l  = up_i[j-1];
      assign mid_l = mid_i[j-1];
      assign dn_l  = dn_i[j-1];
    end

    if (j == MAX_COLS - 1) begin : g_rt_wrap
      assign up_r  = up_i[0];
      assign mid_r = mid_i[0];
      assign dn_r  = dn_i[0];
    end else begin : g_rt
      logic wrap;
      assign wrap  = (COL_CNT_W'(j + 1) == ncols_i);
      assign up_r  = wrap ? up_i[0]  : up_i[j+1];
      assign mid_r = wrap ? mid_i[0] : mid_i[j+1];
      assign dn_r  = wrap ? dn_i[0]  : dn_i[j+1];
    end

    assign active = (COL_CNT_W'(j) < ncols_i);
    assign sum = SUM_W'(up_l) + SUM_W'(up_i[j]) + SUM_W'(up_r)
               + SUM_W'(mid_l) + SUM_W'(mid_r)
               + SUM_W'(dn_l) + SUM_W'(dn_i[j]) + SUM_W'(dn_r);

    // cells beyond the in-use columns keep their value
    assign next_o[j] = active ? ((sum == BIRTH_SUM) || (mid_i[j] && (sum == KEEP_SUM)))
                              : mid_i[j];
  end

endmodule

`default_nettype wire

[hdl/life_grid_generation_step_unit.sv]
// top level of the life grid generation step unit: control, config and grid memory
// depends on lgs_pkg, lgs_ram and lgs_row_update
`timescale 1ns / 1ps
`default_nettype none

// The grid lives in one memory of MAX_ROWS rows, one row of MAX_COLS cells per
// word, with a valid bit per row so that reset clears the grid at once and no
// clearing pass is needed. The unit handles one beat at a time. A cell write is
// a read-modify-write of one row and a cell read reads one row; both pass
// through the cell state to the result register. A generation step sweeps the
// in-use rows through a three-row window at one memory row read per cycle and
// writes each new row back in place (a zero row count acts as one).
// Out-of-range accesses and the unused opcode go straight to the done state,
// where a full output register that has not been taken holds the result back.
// A new beat is accepted once the previous result sits in the output register,
// even if it has not been taken yet.
module life_grid_generation_step_unit
  import lgs_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           opcode_i,
  input  wire logic [ROW_W-1:0]     row_index_i,
  input  wire logic [COL_W-1:0]     col_index_i,
  input  wire logic                 cell_in_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      cell_out_o,
  output logic                      in_range_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL,
    ST_STEP,
    ST_DONE
  } state_e;

  state_e state_q;

  logic [CFG_W-1:0]     rows_q, cols_q;
  logic [ROW_CNT_W-1:0] nrows;
  logic [COL_CNT_W-1:0] ncols;

  logic       in_acc, in_region, cell_op;
  op_e        op_in, op_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic       cell_q;
  logic       res_cell_q, res_range_q;
  logic       out_valid_q, out_cell_q, out_range_q;

  logic                rd_en, rd_vld_q, row_ok_q, sub_d, sub_q, beat;
  logic [ROW_W-1:0]    rd_addr;
  logic [MAX_COLS-1:0] rdata, rdata_m, beat_data;
  logic                wr_en;
  logic [ROW_W-1:0]    wr_addr;
  logic [MAX_COLS-1:0] wr_data;
  logic [MAX_ROWS-1:0] row_valid_q;

  logic [STEP_W-1:0]   iss_q, beat_t_q, last_t;
  logic [MAX_COLS-1:0] up_q, mid_q, dn_q, row0_q, next_row;
  logic                calc_q, calc_last;
  logic [ROW_W-1:0]    calc_row_q;

  // region sizes, zero acts as one and large values saturate
  always_comb begin
    if (rows_q == '0) begin
      nrows = ROW_CNT_W'(1);
    end else if (int'(rows_q) > MAX_ROWS) begin
      nrows = ROW_CNT_W'(MAX_ROWS);
    end else begin
      nrows = ROW_CNT_W'(rows_q);
    end
    if (cols_q == '0) begin
      ncols = COL_CNT_W'(1);
    end else if (int'(cols_q) > MAX_COLS) begin
      ncols = COL_CNT_W'(MAX_COLS);
    end else begin
      ncols = COL_CNT_W'(cols_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RESET;
      cols_q <= COLS_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_ROWS) begin
        rows_q <= cfg_data_i;
      end else begin
        cols_q <= cfg_data_i;
      end
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign op_in      = op_e'(opcode_i);
  assign cell_op    = op_in inside {OP_WRITE, OP_READ};
  assign in_region  = (ROW_CNT_W'(row_index_i) < nrows) && (COL_CNT_W'(col_index_i) < ncols);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_in;
      row_q  <= row_index_i;
      col_q  <= col_index_i;
      cell_q <= cell_in_i;
    end
  end

  // read side: cell access, or for a step the last row first, then rows in order and a replay of row 0
  assign last_t = STEP_W'(nrows) + STEP_W'(1);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = row_index_i;
    sub_d   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (op_in == OP_STEP)) begin
          rd_en   = 1'b1;
          rd_addr = ROW_W'(nrows - ROW_CNT_W'(1));
        end else if (in_acc && cell_op && in_region) begin
          rd_en = 1'b1;
        end
      end
      ST_STEP: begin
        if (iss_q <= STEP_W'(nrows)) begin
          rd_en   = 1'b1;
          rd_addr = ROW_W'(iss_q - STEP_W'(1));
        end else if (iss_q == last_t) begin
          // row 0 is already rewritten, replay its saved old copy
          sub_d = 1'b1;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  lgs_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  assign rdata_m   = rdata & {MAX_COLS{row_ok_q}};
  assign beat      = (state_q == ST_STEP) && (rd_vld_q || sub_q);
  assign beat_data = sub_q ? row0_q : rdata_m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q    <= 1'b0;
      sub_q       <= 1'b0;
      calc_q      <= 1'b0;
      iss_q       <= '0;
      beat_t_q    <= '0;
      row_ok_q    <= 1'b0;
      row_valid_q <= '0;
    end else begin
      rd_vld_q <= rd_en;
      sub_q    <= sub_d;
      calc_q   <= beat && (beat_t_q >= STEP_W'(2));
      if (rd_en) begin
        row_ok_q <= row_valid_q[rd_addr];
      end
      if (wr_en) begin
        row_valid_q[wr_addr] <= 1'b1;
      end
      if (state_q == ST_IDLE) begin
        iss_q    <= STEP_W'(1);
        beat_t_q <= '0;
      end else if (state_q == ST_STEP) begin
        beat_t_q <= iss_q;
        if (iss_q <= last_t) begin
          iss_q <= iss_q + STEP_W'(1);
        end
      end
    end
  end

  // three-row window of old rows
  always_ff @(posedge clk_i) begin
    if (beat) begin
      up_q  <= mid_q;
      mid_q <= dn_q;
      dn_q  <= beat_data;
      if (beat_t_q == STEP_W'(1)) begin
        row0_q <= beat_data;
      end
    end
    calc_row_q <= ROW_W'(beat_t_q - STEP_W'(2));
  end

  lgs_row_update u_update (
    .up_i    (up_q),
    .mid_i   (mid_q),
    .dn_i    (dn_q),
    .ncols_i (ncols),
    .next_o  (next_row)
  );

  assign calc_last = calc_q && (calc_row_q == ROW_W'(nrows - ROW_CNT_W'(1)));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = row_q;
    wr_data = rdata_m;
    if ((state_q == ST_CELL) && (op_q == OP_WRITE)) begin
      wr_en          = 1'b1;
      wr_data[col_q] = cell_q;
    end else if ((state_q == ST_STEP) && calc_q) begin
      wr_en   = 1'b1;
      wr_addr = calc_row_q;
      wr_data = next_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_cell_q  <= 1'b0;
      res_range_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_cell_q  <= 1'b0;
      out_range_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            res_cell_q  <= 1'b0;
            res_range_q <= cell_op && in_region;
            if (op_in == OP_STEP) begin
              state_q <= ST_STEP;
            end else if (cell_op && in_region) begin
              state_q <= ST_CELL;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_CELL: begin
          res_cell_q <= (op_q == OP_READ) && rdata_m[col_q];
          state_q    <= ST_DONE;
        end
        ST_STEP: begin
          if (calc_last) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_cell_q  <= res_cell_q;
            out_range_q <= res_range_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign cell_out_o  = out_cell_q;
  assign in_range_o  = out_range_q;

endmodule

`default_nettype wire

[hdl/lgs_checker.sv]
// port-level checks for the life grid generation step unit, bound to the top level
// depends on life_grid_generation_step_unit
`timescale 1ns / 1ps
`default_nettype none

module lgs_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic cell_out_o,
  input wire logic in_range_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cell_out_o) && $stable(in_range_o))
    else $error("result beat changed while stalled");

  // a live cell is only reported for an in-range access
  a_cell_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(cell_out_o && !in_range_o))
    else $error("cell_out set outside the in-use region");

  // one beat in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat accepted while busy");

  // no result shows in the cycle after a beat is accepted while the output is empty
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared in the cycle after accept");

endmodule

bind life_grid_generation_step_unit lgs_checker u_lgs_checker (.*);

`default_nettype wire
